[rtl/pel_pkg.sv]
`timescale 1ns / 1ps
// pel_pkg: types, codes and color expansion helpers for the palette lookup block.
// No dependencies; imported by every module of the block.
package pel_pkg;

    // item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LOOK8 = 2'd1;
    localparam logic [1:0] OP_QUAD  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // palette source formats
    localparam logic [1:0] FMT_1555 = 2'd0;
    localparam logic [1:0] FMT_565  = 2'd1;
    localparam logic [1:0] FMT_4444 = 2'd2;
    localparam logic [1:0] FMT_8888 = 2'd3;

    localparam int MAX5 = 31;
    localparam int MAX6 = 63;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  entry_index;
        logic [31:0] data_word;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_top_left;
        logic [31:0] pixel_top_right;
        logic [31:0] pixel_bottom_left;
        logic [31:0] pixel_bottom_right;
        logic        is_quad;
    } result_t;

    // classified command; data holds the expanded color, the quad nibbles or the raw word
    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic [7:0]  index;
        logic [31:0] data;
    } cmd_t;

    // floor(v*255/31) = 8v + floor(7v/31)
    function automatic logic [7:0] widen5(logic [4:0] v);
        logic [7:0] t;
        logic [2:0] q;
        begin
            t = {v, 3'b000} - {3'b000, v};
            q = 3'd0;
            for (int k = 1; k <= 7; k++)
            begin
                if (t >= 8'(MAX5 * k))
                    q = q + 3'd1;
            end
            widen5 = {v, 3'b000} + {5'd0, q};
        end
    endfunction

    // floor(v*255/63) = 4v + floor(3v/63)
    function automatic logic [7:0] widen6(logic [5:0] v);
        logic [7:0] t;
        logic [1:0] q;
        begin
            t = {1'b0, v, 1'b0} + {2'b00, v};
            q = 2'd0;
            for (int k = 1; k <= 3; k++)
            begin
                if (t >= 8'(MAX6 * k))
                    q = q + 2'd1;
            end
            widen6 = {v, 2'b00} + {6'd0, q};
        end
    endfunction

    // v*255/15 = 17v exactly
    function automatic logic [7:0] widen4(logic [3:0] v);
        widen4 = {v, v};
    endfunction

    function automatic logic [31:0] expand_word(logic [1:0] fmt, logic [31:0] w);
        logic [7:0]  a;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] y;
        begin
            a = 8'h00;
            r = 8'h00;
            g = 8'h00;
            b = 8'h00;
            y = w;
            case (fmt)
                FMT_1555:
                begin
                    b = widen5(w[4:0]);
                    g = widen5(w[9:5]);
                    r = widen5(w[14:10]);
                    a = w[15] ? 8'hFF : 8'h00;
                    y = {a, r, g, b};
                end
                FMT_565:
                begin
                    b = widen5(w[4:0]);
                    g = widen6(w[10:5]);
                    r = widen5(w[15:11]);
                    a = 8'hFF;
                    y = {a, r, g, b};
                end
                FMT_4444:
                begin
                    b = widen4(w[3:0]);
                    g = widen4(w[7:4]);
                    r = widen4(w[11:8]);
                    a = widen4(w[15:12]);
                    y = {a, r, g, b};
                end
                default:
                    y = w;
            endcase
            expand_word = y;
        end
    endfunction

endpackage

[rtl/pel_front.sv]
`timescale 1ns / 1ps
// pel_front: format register, item classification and color expansion of writes.
// Depends on pel_pkg.
module pel_front #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_wdata,
    input  logic          push,
    input  pel_pkg::item_t item,
    input  logic          stall,
    output logic          full,
    output logic          cmd_push,
    output pel_pkg::cmd_t cmd
);
    import pel_pkg::*;

    logic [1:0] format_reg;
    logic       hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_reg <= FMT_1555;
        else if (cfg_we)
            format_reg <= cfg_wdata;
    end

    assign hit = ({24'd0, item.entry_index} < 32'(PALETTE_ENTRIES));

    assign full     = stall;
    // unused opcode is taken and dropped here
    assign cmd_push = push && !stall && (item.opcode != OP_NONE);

    always_comb
    begin
        cmd.kind  = item.opcode;
        cmd.index = item.entry_index;
        cmd.hit   = hit;
        cmd.data  = item.data_word;
        case (item.opcode)
            OP_WRITE: cmd.data = expand_word(format_reg, item.data_word);
            OP_QUAD:  cmd.hit  = 1'b1;
            default:  cmd.data = item.data_word;
        endcase
    end

endmodule

[rtl/pel_cmd_fifo.sv]
`timescale 1ns / 1ps
// pel_cmd_fifo: short command queue between front and back.
// Depends on pel_pkg (cmd_t, CMDQ_DEPTH, power of two).
module pel_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  pel_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output pel_pkg::cmd_t rd_data,
    output logic          empty
);
    import pel_pkg::*;

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

    cmd_t          entry_reg [CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == (PW+1)'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[rtl/pel_back.sv]
`timescale 1ns / 1ps
// pel_back: palette RAM with clear sweep, lookup sequencer and result register.
// Depends on pel_pkg.
module pel_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pel_pkg::cmd_t   cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    output logic            clearing,
    input  logic            pop,
    output logic            empty,
    output pel_pkg::result_t result
);
    import pel_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [31:0]   mem [PALETTE_ENTRIES];
    logic [31:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [1:0]    slot_reg;
    logic [1:0]    slot_next;
    logic          quad_reg;
    logic          quad_next;
    logic          hit_reg;
    logic          hit_next;
    logic [15:0]   nib_reg;
    logic [15:0]   nib_next;
    logic [1:0]    nsel;
    logic          acc_we;
    logic [31:0]   acc_reg [4];
    logic          out_load;
    logic          out_valid_reg;
    result_t       out_reg;

    assign clearing = clr_reg;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    // slot order TL, TR, BL, BR maps to nibbles 0, 2, 1, 3
    assign nsel     = {slot_next[0], slot_next[1]};

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        quad_next  = quad_reg;
        hit_next   = hit_reg;
        nib_next   = nib_reg;
        cmd_pop    = 1'b0;
        mem_we     = clr_reg;
        mem_wa     = clr_addr_reg;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        acc_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!clr_reg && !cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        OP_WRITE:
                        begin
                            mem_we = cmd.hit;
                            mem_wa = AW'(cmd.index);
                            mem_wd = cmd.data;
                        end
                        OP_LOOK8:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = cmd.hit ? AW'(cmd.index) : '0;
                            hit_next   = cmd.hit;
                            quad_next  = 1'b0;
                            slot_next  = 2'd0;
                            state_next = S_READ;
                        end
                        OP_QUAD:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = AW'(cmd.data[3:0]);
                            hit_next   = 1'b1;
                            quad_next  = 1'b1;
                            slot_next  = 2'd0;
                            nib_next   = cmd.data[15:0];
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                acc_we = 1'b1;
                if (quad_reg && (slot_reg != 2'd3))
                begin
                    slot_next = slot_reg + 2'd1;
                    mem_re    = 1'b1;
                    mem_ra    = AW'(nib_reg[{nsel, 2'b00} +: 4]);
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            state_reg     <= S_IDLE;
            slot_reg      <= 2'd0;
            quad_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                    clr_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            state_reg <= state_next;
            slot_reg  <= slot_next;
            quad_reg  <= quad_next;
            hit_reg   <= hit_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        nib_reg <= nib_next;
        // out-of-range 8bpp index reads as zero
        if (acc_we)
            acc_reg[slot_reg] <= hit_reg ? rd_data_reg : '0;
        if (out_load)
        begin
            out_reg.pixel_top_left     <= acc_reg[0];
            out_reg.pixel_top_right    <= quad_reg ? acc_reg[1] : '0;
            out_reg.pixel_bottom_left  <= quad_reg ? acc_reg[2] : '0;
            out_reg.pixel_bottom_right <= quad_reg ? acc_reg[3] : '0;
            out_reg.is_quad            <= quad_reg;
        end
    end

endmodule

[rtl/palette_expand_and_lookup.sv]
`timescale 1ns / 1ps
// palette_expand_and_lookup: top level; front, command queue and back.
// Depends on pel_pkg, pel_front, pel_cmd_fifo, pel_back.

// After reset the palette RAM is swept to zero, one entry per cycle, over all
// PALETTE_ENTRIES entries; full stays high meanwhile, format writes are taken.
// The front takes one beat per cycle while the two-entry command queue has
// room. The back owns a single-port-read palette RAM and works one command
// at a time: a write is done as it is popped, an 8bpp lookup makes one read
// and a 4bpp quad four reads through the one read port. Results wait in a
// one-beat output register; the back keeps working until its next result is
// ready, then holds that result until the waiting beat is popped.
// Unused opcode beats are accepted and dropped.
module palette_expand_and_lookup #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata,
    input  logic             push,
    output logic             full,
    input  pel_pkg::item_t   item,
    input  logic             pop,
    output logic             empty,
    output pel_pkg::result_t result
);
    import pel_pkg::*;

    cmd_t f_cmd;
    cmd_t q_cmd;
    logic f_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic clearing;

    pel_front #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .item      (item),
        .stall     (q_full || clearing),
        .full      (full),
        .cmd_push  (f_push),
        .cmd       (f_cmd)
    );

    pel_cmd_fifo u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    pel_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .clearing  (clearing),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

[rtl/pel_checker.sv]
`timescale 1ns / 1ps
// pel_checker: port-level checks for palette_expand_and_lookup, bound below.
// Depends on pel_pkg.
module pel_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_we,
    input logic [1:0]       cfg_wdata,
    input logic             push,
    input logic             full,
    input pel_pkg::item_t   item,
    input logic             pop,
    input logic             empty,
    input pel_pkg::result_t result
);
    import pel_pkg::*;

    // result beat holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished before pop");

    // single-index results carry zeros in the other three pixels
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.is_quad) |->
        (result.pixel_top_right == '0 && result.pixel_bottom_left == '0 &&
         result.pixel_bottom_right == '0))
        else $error("8bpp result with nonzero quad pixels");

    // clear sweep keeps input closed right after reset
    a_clear_full: assert property (@(posedge clk)
        !rst_n |=> full)
        else $error("input open during palette clear");

    // a reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result shown after reset");

endmodule

bind palette_expand_and_lookup pel_checker u_pel_checker (.*);

[verif/palette_expand_and_lookup_test.sv]
`timescale 1ns / 1ps
// palette_expand_and_lookup_test: self-checking bench for the palette expand and lookup block.
// Depends on pel_pkg and palette_expand_and_lookup; shadows the palette and checks every lookup beat.

module palette_expand_and_lookup_test;
    import pel_pkg::*;

    localparam int ENTRIES      = 256;
    localparam int BEATS_PER_PH = 180;
    localparam int SETTLE_CYC   = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIRECTED   = 17;
    localparam int N_PHASES     = 9;

    localparam result_t NO_PIX = '0;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [31:0] word;
        bit          typed;
        result_t     want;
    } row_t;

    // typed rows carry a hand-checked result; others go through the shadow palette
    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{OP_LOOK8, 8'd255, 32'h0000_0000, 1'b1, NO_PIX},
        '{OP_QUAD,  8'hFF,  32'hFFFF_0000, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
        '{OP_WRITE, 8'd0,   32'hFFFF_FFFF, 1'b0, NO_PIX},
        '{OP_WRITE, 8'd255, 32'h0000_7FFF, 1'b0, NO_PIX},
        '{OP_WRITE, 8'd1,   32'hFFFF_0000, 1'b0, NO_PIX},
        '{OP_WRITE, 8'd2,   32'h0000_8000, 1'b0, NO_PIX},
        '{OP_LOOK8, 8'd0,   32'hDEAD_BEEF, 1'b1, '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_LOOK8, 8'd255, 32'h0000_0000, 1'b1, '{32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_LOOK8, 8'd1,   32'h0000_0000, 1'b1, NO_PIX},
        '{OP_LOOK8, 8'd2,   32'h0000_0000, 1'b1, '{32'hFF00_0000, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_WRITE, 8'd15,  32'h1234_5A5A, 1'b0, NO_PIX},
        '{OP_WRITE, 8'd3,   32'h0000_0421, 1'b0, NO_PIX},
        '{OP_QUAD,  8'hFF,  32'hABCD_F210, 1'b0, NO_PIX},
        '{OP_NONE,  8'd0,   32'h0000_0000, 1'b0, NO_PIX},
        '{OP_LOOK8, 8'd0,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_QUAD,  8'h00,  32'h0000_3F20, 1'b0, NO_PIX},
        '{OP_LOOK8, 8'd3,   32'h0000_0000, 1'b0, NO_PIX}
    };

    localparam logic [1:0] PHASE_FMT [N_PHASES] = '{
        FMT_1555, FMT_565, FMT_4444, FMT_8888, FMT_4444, FMT_1555, FMT_8888, FMT_565, FMT_8888
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_we = 1'b0;
    logic [1:0] cfg_wdata = FMT_1555;
    logic    push = 1'b0;
    logic    full;
    item_t   item = '0;
    logic    pop = 1'b0;
    logic    empty;
    result_t result;

    logic [31:0] shadow_palette [ENTRIES];
    logic [1:0]  shadow_format = FMT_1555;
    result_t     pending_pixels [$];
    int          failures = 0;
    int          cycles = 0;
    int          send_idle_pct = 33;
    int          pop_idle_pct = 56;

    palette_expand_and_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .item      (item),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("palette_expand_and_lookup_test failed");
            $finish;
        end
    end

    // widen a channel to 8 bits as floor(v*255/max)
    function automatic logic [7:0] widen_chan(int unsigned v, int unsigned max);
        int unsigned y;
        y = (v * 255) / max;
        return y[7:0];
    endfunction

    function automatic logic [31:0] expand_color(logic [1:0] fmt, logic [31:0] w);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (fmt)
            FMT_1555:
            begin
                b = widen_chan(32'(w[4:0]), 31);
                g = widen_chan(32'(w[9:5]), 31);
                r = widen_chan(32'(w[14:10]), 31);
                a = w[15] ? 8'hFF : 8'h00;
            end
            FMT_565:
            begin
                b = widen_chan(32'(w[4:0]), 31);
                g = widen_chan(32'(w[10:5]), 63);
                r = widen_chan(32'(w[15:11]), 31);
                a = 8'hFF;
            end
            FMT_4444:
            begin
                b = widen_chan(32'(w[3:0]), 15);
                g = widen_chan(32'(w[7:4]), 15);
                r = widen_chan(32'(w[11:8]), 15);
                a = widen_chan(32'(w[15:12]), 15);
            end
            default:
                return w;
        endcase
        return {a, r, g, b};
    endfunction

    // updates the shadow palette; returns 1 when the beat yields a lookup result
    function automatic bit predict_lookup(item_t beat, output result_t pix);
        pix = '0;
        case (beat.opcode)
            OP_WRITE:
            begin
                shadow_palette[beat.entry_index] = expand_color(shadow_format, beat.data_word);
                return 1'b0;
            end
            OP_LOOK8:
            begin
                pix.pixel_top_left = shadow_palette[beat.entry_index];
                return 1'b1;
            end
            OP_QUAD:
            begin
                pix.pixel_top_left     = shadow_palette[{4'd0, beat.data_word[3:0]}];
                pix.pixel_bottom_left  = shadow_palette[{4'd0, beat.data_word[7:4]}];
                pix.pixel_top_right    = shadow_palette[{4'd0, beat.data_word[11:8]}];
                pix.pixel_bottom_right = shadow_palette[{4'd0, beat.data_word[15:12]}];
                pix.is_quad = 1'b1;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_beat(input item_t beat);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= beat;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
    endtask

    task automatic send_and_track(input item_t beat, input bit typed, input result_t typed_pix);
        result_t pix;
        bit      has_pix;
        send_beat(beat);
        has_pix = predict_lookup(beat, pix);
        if (typed)
            pix = typed_pix;
        if (has_pix)
            pending_pixels.push_back(pix);
    endtask

    // wait for all lookups to come back, then let any trailing writes retire
    task automatic drain;
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_format(input logic [1:0] fmt);
        cfg_we <= 1'b1;
        cfg_wdata <= fmt;
        shadow_format = fmt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
        pop <= rst_n && ($urandom_range(0, 99) >= pop_idle_pct);

    // pop and empty are stable from the falling edge to the accepting edge
    always @(negedge clk)
    begin : result_check
        result_t want;
        if (pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result beat with no lookup pending: %h", result);
                failures++;
            end
            else
            begin
                want = pending_pixels[0];
                pending_pixels.delete(0);
                check_field("pixel_top_left", want.pixel_top_left, result.pixel_top_left);
                check_field("pixel_top_right", want.pixel_top_right, result.pixel_top_right);
                check_field("pixel_bottom_left", want.pixel_bottom_left,
                            result.pixel_bottom_left);
                check_field("pixel_bottom_right", want.pixel_bottom_right,
                            result.pixel_bottom_right);
                check_field("is_quad", {31'd0, want.is_quad}, {31'd0, result.is_quad});
            end
        end
    end

    initial
    begin : stimulus
        item_t beat;
        int    roll;
        int    counted;
        foreach (shadow_palette[i])
            shadow_palette[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset format, sender 33 / receiver 56 idle
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            beat.opcode      = DIRECTED[r].op;
            beat.entry_index = DIRECTED[r].idx;
            beat.data_word   = DIRECTED[r].word;
            send_and_track(beat, DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            set_format(PHASE_FMT[p]);
            case (p / 3)
                0:
                begin
                    send_idle_pct = 33;
                    pop_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    pop_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    pop_idle_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < BEATS_PER_PH)
            begin
                roll = $urandom_range(0, 99);
                beat.data_word = $urandom();
                beat.entry_index = 8'($urandom_range(0, 255));
                if (roll < 40)
                begin
                    beat.opcode = OP_WRITE;
                    // keep the quad-reachable entries busy
                    if ($urandom_range(0, 1) == 0)
                        beat.entry_index = 8'($urandom_range(0, 15));
                end
                else if (roll < 68)
                begin
                    beat.opcode = OP_LOOK8;
                    if ($urandom_range(0, 2) == 0)
                        beat.entry_index = 8'($urandom_range(0, 15));
                end
                else if (roll < 95)
                    beat.opcode = OP_QUAD;
                else
                    beat.opcode = OP_NONE;
                if (beat.opcode != OP_NONE)
                    counted++;
                send_and_track(beat, 1'b0, NO_PIX);
            end
        end

        drain();
        if (failures == 0)
            $display("palette_expand_and_lookup_test passed");
        else
            $display("palette_expand_and_lookup_test failed");
        $finish;
    end

endmodule
